// ===== rtl/core/ucrd_pkg.sv =====
package ucrd_pkg;

  // Number of code point ranges that take part in the compare (1 to 4).
  localparam int RANGE_PAIRS = 4;

  localparam int POINT_W   = 21;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 2;
  localparam int CFG_IDX_W = 4;

  // Register map of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE2_LOW  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE2_HIGH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE3_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE3_HIGH = 4'd7;

  localparam logic [POINT_W-1:0] RANGE_LOW_RST  = 21'd1;
  localparam logic [POINT_W-1:0] RANGE_HIGH_RST = 21'd0;

  // UTF-8 byte classes.
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG   = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;

  localparam int CONT_W = 6;

  typedef struct packed {
    logic [POINT_W-1:0] low;
    logic [POINT_W-1:0] high;
  } range_t;

  typedef struct packed {
    logic [PEND_W-1:0]  pending;
    logic [POINT_W-1:0] partial;
  } dec_state_t;

endpackage

// ===== rtl/core/ucrd_in_if.sv =====
interface ucrd_in_if import ucrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              last_of_name;

  modport source (output valid, output name_byte, output last_of_name, input ready);
  modport sink   (input valid, input name_byte, input last_of_name, output ready);
endinterface

// ===== rtl/core/ucrd_out_if.sv =====
interface ucrd_out_if ();
  logic valid;
  logic ready;
  logic range_hit;

  modport source (output valid, output range_hit, input ready);
  modport sink   (input valid, input range_hit, output ready);
endinterface

// ===== rtl/core/ucrd_cfg_if.sv =====
interface ucrd_cfg_if import ucrd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [POINT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ucrd_cfg_regs.sv =====
module ucrd_cfg_regs import ucrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [POINT_W-1:0]   wr_data,
  output range_t               ranges [RANGE_PAIRS]
);

  range_t range_r   [RANGE_PAIRS];
  range_t range_nxt [RANGE_PAIRS];

  // Even index is the low bound of a pair, odd index the high bound.
  // Indexes of pairs that are not compared, and beyond the map, are dropped.
  always_comb begin
    for (int p = 0; p < RANGE_PAIRS; p++) begin
      range_nxt[p] = range_r[p];
      if (wr_en && (wr_index == CFG_IDX_W'(2 * p))) begin
        range_nxt[p].low = wr_data;
      end
      if (wr_en && (wr_index == CFG_IDX_W'(2 * p + 1))) begin
        range_nxt[p].high = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < RANGE_PAIRS; p++) begin
      if (!rst_n) begin
        range_r[p].low  <= RANGE_LOW_RST;
        range_r[p].high <= RANGE_HIGH_RST;
      end else begin
        range_r[p] <= range_nxt[p];
      end
    end
  end

  assign ranges = range_r;

endmodule

// ===== rtl/core/ucrd_utf8_step.sv =====
module ucrd_utf8_step import ucrd_pkg::*; (
  input  dec_state_t         state,
  input  logic [BYTE_W-1:0]  name_byte,
  output dec_state_t         state_nxt,
  output logic               point_done,
  output logic [POINT_W-1:0] point
);

  logic               is_cont;
  logic [POINT_W-1:0] shifted;
  logic [PEND_W-1:0]  pend_dec;

  assign is_cont  = (name_byte & CONT_MASK) == CONT_TAG;
  assign shifted  = {state.partial[POINT_W-CONT_W-1:0], name_byte[CONT_W-1:0]};
  assign pend_dec = state.pending - PEND_W'(1);

  // The partial value is zero whenever nothing is pending, so a lead byte
  // always starts from a clean state.
  always_comb begin
    state_nxt  = '0;
    point_done = 1'b0;
    point      = '0;
    if ((state.pending != '0) && is_cont) begin
      if (pend_dec == '0) begin
        point_done = 1'b1;
        point      = shifted;
      end else begin
        state_nxt.pending = pend_dec;
        state_nxt.partial = shifted;
      end
    end else if (name_byte < ASCII_LIMIT) begin
      point_done = 1'b1;
      point      = POINT_W'(name_byte);
    end else if ((name_byte & LEAD2_MASK) == LEAD2_TAG) begin
      state_nxt.pending = PEND_W'(1);
      state_nxt.partial = POINT_W'(name_byte & LEAD2_BITS);
    end else if ((name_byte & LEAD3_MASK) == LEAD3_TAG) begin
      state_nxt.pending = PEND_W'(2);
      state_nxt.partial = POINT_W'(name_byte & LEAD3_BITS);
    end else if ((name_byte & LEAD4_MASK) == LEAD4_TAG) begin
      state_nxt.pending = PEND_W'(3);
      state_nxt.partial = POINT_W'(name_byte & LEAD4_BITS);
    end
  end

endmodule

// ===== rtl/core/ucrd_range_match.sv =====
module ucrd_range_match import ucrd_pkg::*; (
  input  range_t             ranges [RANGE_PAIRS],
  input  logic [POINT_W-1:0] point,
  output logic               hit
);

  logic [RANGE_PAIRS-1:0] pair_hit;

  // A pair whose low bound lies above its high bound can never match.
  always_comb begin
    for (int p = 0; p < RANGE_PAIRS; p++) begin
      pair_hit[p] = (point >= ranges[p].low) && (point <= ranges[p].high);
    end
  end

  assign hit = (point != '0) && (|pair_hit);

endmodule

// ===== rtl/core/utf8_codepoint_range_detector.sv =====
// UTF-8 code point range detector. Bytes of a name arrive one transaction
// at a time on in_ch, the final byte flagged by last_of_name. One- to
// four-byte sequences are decoded to 21-bit code points (overlong forms and
// surrogates pass), and every nonzero code point is compared against four
// inclusive ranges set through cfg_ch (index 2k is the low bound and 2k+1
// the high bound of range k; low above high makes the range empty; writes
// to other indexes are ignored). A bad lead byte yields nothing, a bad
// continuation byte drops the pending sequence and is decoded again as a
// lead, and a sequence cut off at the end of the name yields nothing. The
// block emits exactly one out_ch transaction per name, on its last byte,
// with range_hit set if any code point of the name hit a range. Throughput
// is one byte per clock while no last byte stalls. After the last byte is
// accepted into the input register, it is decoded and compared, and the
// result register drives out_ch.valid. Only a last byte in the input
// register stalls, only while the previous result is still held in the
// result register, and in_ch.ready is low meanwhile. Ranges must only be
// written while no transaction is in flight; a change between the bytes of
// one name applies to the code points completed after it.
module utf8_codepoint_range_detector import ucrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ucrd_in_if.sink    in_ch,
  ucrd_out_if.source out_ch,
  ucrd_cfg_if.sink   cfg_ch
);

  // Input register.
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Decoder state carried from byte to byte within a name.
  dec_state_t dec_r;
  dec_state_t dec_nxt;
  logic       hit_r;
  logic       hit_nxt;

  // Result register.
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_hit_r;
  logic out_hit_nxt;

  dec_state_t         step_state;
  logic               point_done;
  logic [POINT_W-1:0] point;
  logic               point_hit;
  range_t             ranges [RANGE_PAIRS];

  logic advance;
  logic take_in;
  logic fire;

  // The configuration port never stalls.
  assign cfg_ch.ready = 1'b1;

  ucrd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .ranges   (ranges)
  );

  ucrd_utf8_step u_step (
    .state      (dec_r),
    .name_byte  (s1_byte_r),
    .state_nxt  (step_state),
    .point_done (point_done),
    .point      (point)
  );

  ucrd_range_match u_match (
    .ranges (ranges),
    .point  (point),
    .hit    (point_hit)
  );

  // The byte in the input register moves on unless it ends a name and the
  // result register still holds a result that has not been taken. While it
  // waits, in_ch.ready is low, so no new byte is taken either.
  assign advance     = !s1_valid_r || !s1_last_r || !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign take_in     = in_ch.valid && advance;
  assign fire        = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt  = take_in ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    dec_nxt       = dec_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_hit_nxt   = out_hit_r;
    if (fire) begin
      dec_nxt = step_state;
      hit_nxt = hit_r | (point_done & point_hit);
      if (s1_last_r) begin
        // End of name: report and start the next name from scratch.
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit_nxt;
        dec_nxt       = '0;
        hit_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      dec_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      dec_r       <= dec_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_byte_r <= in_ch.name_byte;
      s1_last_r <= in_ch.last_of_name;
    end
    out_hit_r <= out_hit_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.range_hit = out_hit_r;

endmodule
